// ===== sv/lem_pkg.sv =====
// Shared constants, microcode types and the control program of the Lorenz magnitude block
package lem_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 22;
   localparam int STEP_WIDTH          = 6;
   localparam int REG_INDEX_WIDTH     = 2;

   typedef logic [3:0] op_type;
   localparam op_type OP_NOP    = 4'd0;
   localparam op_type OP_ADD    = 4'd1;
   localparam op_type OP_SUB    = 4'd2;
   localparam op_type OP_MLO    = 4'd3;
   localparam op_type OP_MHI    = 4'd4;
   localparam op_type OP_RND    = 4'd5;
   localparam op_type OP_ACC    = 4'd6;
   localparam op_type OP_COMMIT = 4'd7;
   localparam op_type OP_SQINIT = 4'd8;
   localparam op_type OP_SQSTEP = 4'd9;
   localparam op_type OP_DONE   = 4'd10;

   typedef logic [3:0] sel_type;
   localparam sel_type SEL_X      = 4'd0;
   localparam sel_type SEL_Y      = 4'd1;
   localparam sel_type SEL_Z      = 4'd2;
   localparam sel_type SEL_T      = 4'd3;
   localparam sel_type SEL_U      = 4'd4;
   localparam sel_type SEL_SIGMA  = 4'd5;
   localparam sel_type SEL_RHO    = 4'd6;
   localparam sel_type SEL_BETA   = 4'd7;
   localparam sel_type SEL_STEP   = 4'd8;
   localparam sel_type SEL_SAMPLE = 4'd9;

   typedef logic [2:0] dst_type;
   localparam dst_type DST_NONE = 3'd0;
   localparam dst_type DST_T    = 3'd1;
   localparam dst_type DST_U    = 3'd2;
   localparam dst_type DST_NX   = 3'd3;
   localparam dst_type DST_NY   = 3'd4;
   localparam dst_type DST_Z    = 3'd5;

   typedef logic [REG_INDEX_WIDTH-1:0] reg_index_type;
   localparam reg_index_type REG_SIGMA = 2'd0;
   localparam reg_index_type REG_RHO   = 2'd1;
   localparam reg_index_type REG_BETA  = 2'd2;
   localparam reg_index_type REG_STEP  = 2'd3;

   typedef logic [STEP_WIDTH-1:0] step_type;

   typedef struct packed {
      op_type   op;
      sel_type  src_a;
      sel_type  src_b;
      dst_type  dst;
      logic     loop;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic count_zero;
      logic saturated;
   } dp_status_type;

   localparam step_type  SQRT_STEP  = 6'd42;
   localparam ucode_type UCODE_IDLE = '{OP_NOP, SEL_X, SEL_X, DST_NONE, 1'b0, 6'd0};

   function automatic int csr_data_width(input int value_width);
      return (value_width > 32) ? 64 : 32;
   endfunction

   function automatic int csr_addr_shift(input int value_width);
      return (value_width > 32) ? 3 : 2;
   endfunction

   function automatic int csr_addr_width(input int value_width);
      return csr_addr_shift(value_width) + REG_INDEX_WIDTH;
   endfunction

   function automatic ucode_type uword(input op_type op, input sel_type a, input sel_type b,
                                       input dst_type d);
      return '{op, a, b, d, 1'b0, 6'd0};
   endfunction

   // Control program: one Euler step, then the four squares and the root
   function automatic ucode_type prog_word(input step_type step);
      ucode_type w;
      case (step)
         6'd0:  w = uword(OP_SUB, SEL_Y, SEL_X, DST_T);
         6'd1:  w = uword(OP_MLO, SEL_SIGMA, SEL_T, DST_NONE);
         6'd2:  w = uword(OP_MHI, SEL_SIGMA, SEL_T, DST_NONE);
         6'd3:  w = uword(OP_RND, SEL_X, SEL_X, DST_T);
         6'd4:  w = uword(OP_MLO, SEL_STEP, SEL_T, DST_NONE);
         6'd5:  w = uword(OP_MHI, SEL_STEP, SEL_T, DST_NONE);
         6'd6:  w = uword(OP_RND, SEL_X, SEL_X, DST_T);
         6'd7:  w = uword(OP_ADD, SEL_X, SEL_T, DST_NX);
         6'd8:  w = uword(OP_SUB, SEL_RHO, SEL_Z, DST_T);
         6'd9:  w = uword(OP_MLO, SEL_X, SEL_T, DST_NONE);
         6'd10: w = uword(OP_MHI, SEL_X, SEL_T, DST_NONE);
         6'd11: w = uword(OP_RND, SEL_X, SEL_X, DST_T);
         6'd12: w = uword(OP_SUB, SEL_T, SEL_Y, DST_T);
         6'd13: w = uword(OP_MLO, SEL_STEP, SEL_T, DST_NONE);
         6'd14: w = uword(OP_MHI, SEL_STEP, SEL_T, DST_NONE);
         6'd15: w = uword(OP_RND, SEL_X, SEL_X, DST_T);
         6'd16: w = uword(OP_ADD, SEL_Y, SEL_T, DST_NY);
         6'd17: w = uword(OP_MLO, SEL_X, SEL_Y, DST_NONE);
         6'd18: w = uword(OP_MHI, SEL_X, SEL_Y, DST_NONE);
         6'd19: w = uword(OP_RND, SEL_X, SEL_X, DST_T);
         6'd20: w = uword(OP_MLO, SEL_BETA, SEL_Z, DST_NONE);
         6'd21: w = uword(OP_MHI, SEL_BETA, SEL_Z, DST_NONE);
         6'd22: w = uword(OP_RND, SEL_X, SEL_X, DST_U);
         6'd23: w = uword(OP_SUB, SEL_T, SEL_U, DST_T);
         6'd24: w = uword(OP_MLO, SEL_STEP, SEL_T, DST_NONE);
         6'd25: w = uword(OP_MHI, SEL_STEP, SEL_T, DST_NONE);
         6'd26: w = uword(OP_RND, SEL_X, SEL_X, DST_T);
         6'd27: w = uword(OP_ADD, SEL_Z, SEL_T, DST_Z);
         6'd28: w = uword(OP_COMMIT, SEL_X, SEL_X, DST_NONE);
         6'd29: w = uword(OP_MLO, SEL_X, SEL_X, DST_NONE);
         6'd30: w = uword(OP_MHI, SEL_X, SEL_X, DST_NONE);
         6'd31: w = uword(OP_ACC, SEL_X, SEL_X, DST_NONE);
         6'd32: w = uword(OP_MLO, SEL_Y, SEL_Y, DST_NONE);
         6'd33: w = uword(OP_MHI, SEL_Y, SEL_Y, DST_NONE);
         6'd34: w = uword(OP_ACC, SEL_X, SEL_X, DST_NONE);
         6'd35: w = uword(OP_MLO, SEL_Z, SEL_Z, DST_NONE);
         6'd36: w = uword(OP_MHI, SEL_Z, SEL_Z, DST_NONE);
         6'd37: w = uword(OP_ACC, SEL_X, SEL_X, DST_NONE);
         6'd38: w = uword(OP_MLO, SEL_SAMPLE, SEL_SAMPLE, DST_NONE);
         6'd39: w = uword(OP_MHI, SEL_SAMPLE, SEL_SAMPLE, DST_NONE);
         6'd40: w = uword(OP_ACC, SEL_X, SEL_X, DST_NONE);
         6'd41: w = uword(OP_SQINIT, SEL_X, SEL_X, DST_NONE);
         6'd42: w = '{OP_SQSTEP, SEL_X, SEL_X, DST_NONE, 1'b1, SQRT_STEP};
         6'd43: w = uword(OP_DONE, SEL_X, SEL_X, DST_NONE);
         default: w = UCODE_IDLE;
      endcase
      return w;
   endfunction

endpackage

// ===== sv/lem_datapath.sv =====
// Datapath of the Lorenz magnitude block: state, shared multiplier, clip unit and square root
module lem_datapath #(
   parameter int VALUE_WIDTH = lem_pkg::VALUE_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = lem_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [VALUE_WIDTH-1:0] sample_in,
   input  lem_pkg::ucode_type            ucode,
   input  logic signed [VALUE_WIDTH-1:0] sigma_gain,
   input  logic signed [VALUE_WIDTH-1:0] rho_gain,
   input  logic signed [VALUE_WIDTH-1:0] beta_gain,
   input  logic        [FRAC_BITS:0]     step_size,
   output lem_pkg::dp_status_type        status,
   output logic        [VALUE_WIDTH-2:0] magnitude
);

   localparam int W          = VALUE_WIDTH;
   localparam int F          = FRAC_BITS;
   localparam int MagWidth   = (W > F + 1) ? W : F + 1;
   localparam int SelWidth   = MagWidth + 1;
   localparam int AluWidth   = SelWidth + 1;
   localparam int DigWidth   = (MagWidth + 1) / 2;
   localparam int PartWidth  = MagWidth + DigWidth;
   localparam int ProdWidth  = 2 * MagWidth;
   localparam int SumWidth   = 2 * W + 1;
   localparam int RadWidth   = 2 * W + 2;
   localparam int RootWidth  = W + 1;
   localparam int RemWidth   = W + 2;
   localparam int CandWidth  = W + 4;
   localparam int CntWidth   = $clog2(W + 1);

   localparam longint OneQ      = longint'(1) << F;
   localparam longint VMaxL     = (longint'(1) << (W - 1)) - 1;
   localparam longint PosXRaw   = (OneQ + 5) / 10;
   localparam longint PosXReset = (PosXRaw > VMaxL) ? VMaxL : PosXRaw;

   localparam logic [ProdWidth-1:0] RoundHalf =
      {{(ProdWidth - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
   localparam logic [ProdWidth-1:0] LimPos = {{(ProdWidth - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic [ProdWidth-1:0] LimNeg =
      {{(ProdWidth - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};
   localparam logic signed [AluWidth-1:0] AluMax =
      {{(AluWidth - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic signed [AluWidth-1:0] AluMin =
      {{(AluWidth - W + 1){1'b1}}, {(W - 1){1'b0}}};

   logic signed [W-1:0]         x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [W-1:0]         nx_ff, nx_in, ny_ff, ny_in, t_ff, t_in, u_ff, u_in;
   logic signed [W-1:0]         sample_ff, sample_in_d;
   logic [ProdWidth-1:0]        prod_ff, prod_in;
   logic                        neg_ff, neg_in;
   logic [SumWidth-1:0]         sum_ff, sum_in;
   logic                        flag_ff, flag_in;
   logic [RadWidth-1:0]         rad_ff, rad_in;
   logic [RemWidth-1:0]         rem_ff, rem_in;
   logic [RootWidth-1:0]        root_ff, root_in;
   logic [CntWidth-1:0]         cnt_ff, cnt_in;

   logic signed [SelWidth-1:0]  opa, opb;
   logic [MagWidth-1:0]         mag_a, mag_b;
   logic [DigWidth-1:0]         digit;
   logic [PartWidth-1:0]        part;
   logic [ProdWidth-1:0]        rnd_sum, rnd_q, rnd_lim;
   logic                        rnd_ovf;
   logic [W-1:0]                rnd_mag;
   logic signed [W-1:0]         rnd_val;
   logic signed [AluWidth-1:0]  alu_sum;
   logic                        alu_ovf;
   logic signed [W-1:0]         alu_val;
   logic signed [W-1:0]         res_val;
   logic                        res_ovf;
   logic [CandWidth-1:0]        cand, trial;
   logic                        cand_ge;
   logic                        root_ovf;

   always_comb begin
      case (ucode.src_a)
         lem_pkg::SEL_X:      opa = SelWidth'(x_ff);
         lem_pkg::SEL_Y:      opa = SelWidth'(y_ff);
         lem_pkg::SEL_Z:      opa = SelWidth'(z_ff);
         lem_pkg::SEL_T:      opa = SelWidth'(t_ff);
         lem_pkg::SEL_U:      opa = SelWidth'(u_ff);
         lem_pkg::SEL_SIGMA:  opa = SelWidth'(sigma_gain);
         lem_pkg::SEL_RHO:    opa = SelWidth'(rho_gain);
         lem_pkg::SEL_BETA:   opa = SelWidth'(beta_gain);
         lem_pkg::SEL_STEP:   opa = signed'(SelWidth'(step_size));
         lem_pkg::SEL_SAMPLE: opa = SelWidth'(sample_ff);
         default:             opa = '0;
      endcase
   end

   always_comb begin
      case (ucode.src_b)
         lem_pkg::SEL_X:      opb = SelWidth'(x_ff);
         lem_pkg::SEL_Y:      opb = SelWidth'(y_ff);
         lem_pkg::SEL_Z:      opb = SelWidth'(z_ff);
         lem_pkg::SEL_T:      opb = SelWidth'(t_ff);
         lem_pkg::SEL_U:      opb = SelWidth'(u_ff);
         lem_pkg::SEL_SIGMA:  opb = SelWidth'(sigma_gain);
         lem_pkg::SEL_RHO:    opb = SelWidth'(rho_gain);
         lem_pkg::SEL_BETA:   opb = SelWidth'(beta_gain);
         lem_pkg::SEL_STEP:   opb = signed'(SelWidth'(step_size));
         lem_pkg::SEL_SAMPLE: opb = SelWidth'(sample_ff);
         default:             opb = '0;
      endcase
   end

   // Two-digit multiply: low half of operand b, then the high half
   always_comb begin
      mag_a = opa[SelWidth-1] ? MagWidth'(-opa) : MagWidth'(opa);
      mag_b = opb[SelWidth-1] ? MagWidth'(-opb) : MagWidth'(opb);
      digit = (ucode.op == lem_pkg::OP_MHI) ? DigWidth'(mag_b >> DigWidth)
                                            : mag_b[DigWidth-1:0];
      part  = PartWidth'(mag_a) * PartWidth'(digit);
   end

   // Round half away from zero, then clip against the signed range
   always_comb begin
      rnd_sum = prod_ff + RoundHalf;
      rnd_q   = rnd_sum >> F;
      rnd_lim = neg_ff ? LimNeg : LimPos;
      rnd_ovf = (rnd_q > rnd_lim);
      rnd_mag = rnd_ovf ? rnd_lim[W-1:0] : rnd_q[W-1:0];
      rnd_val = neg_ff ? signed'(-rnd_mag) : signed'(rnd_mag);
   end

   always_comb begin
      if (ucode.op == lem_pkg::OP_ADD) begin
         alu_sum = AluWidth'(opa) + AluWidth'(opb);
      end else begin
         alu_sum = AluWidth'(opa) - AluWidth'(opb);
      end
      alu_ovf = 1'b0;
      if (alu_sum > AluMax) begin
         alu_val = AluMax[W-1:0];
         alu_ovf = 1'b1;
      end else if (alu_sum < AluMin) begin
         alu_val = AluMin[W-1:0];
         alu_ovf = 1'b1;
      end else begin
         alu_val = alu_sum[W-1:0];
      end
      res_val = (ucode.op == lem_pkg::OP_RND) ? rnd_val : alu_val;
      res_ovf = (ucode.op == lem_pkg::OP_RND) ? rnd_ovf : alu_ovf;
   end

   // One root bit per step
   always_comb begin
      cand    = {rem_ff, rad_ff[RadWidth-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      cand_ge = (cand >= trial);
   end

   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      nx_in       = nx_ff;
      ny_in       = ny_ff;
      t_in        = t_ff;
      u_in        = u_ff;
      sample_in_d = sample_ff;
      prod_in     = prod_ff;
      neg_in      = neg_ff;
      sum_in      = sum_ff;
      flag_in     = flag_ff;
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      cnt_in      = cnt_ff;
      if (start) begin
         sample_in_d = sample_in;
         sum_in      = '0;
         flag_in     = 1'b0;
      end else begin
         case (ucode.op)
            lem_pkg::OP_ADD, lem_pkg::OP_SUB, lem_pkg::OP_RND: begin
               flag_in = flag_ff | res_ovf;
               case (ucode.dst)
                  lem_pkg::DST_T:  t_in  = res_val;
                  lem_pkg::DST_U:  u_in  = res_val;
                  lem_pkg::DST_NX: nx_in = res_val;
                  lem_pkg::DST_NY: ny_in = res_val;
                  lem_pkg::DST_Z:  z_in  = res_val;
                  default: ;
               endcase
            end
            lem_pkg::OP_MLO: begin
               prod_in = ProdWidth'(part);
               neg_in  = opa[SelWidth-1] ^ opb[SelWidth-1];
            end
            lem_pkg::OP_MHI: begin
               prod_in = prod_ff + (ProdWidth'(part) << DigWidth);
            end
            lem_pkg::OP_ACC: begin
               sum_in = sum_ff + {1'b0, prod_ff[2*W-1:0]};
            end
            lem_pkg::OP_COMMIT: begin
               x_in = nx_ff;
               y_in = ny_ff;
            end
            lem_pkg::OP_SQINIT: begin
               rad_in  = {1'b0, sum_ff};
               rem_in  = '0;
               root_in = '0;
               cnt_in  = CntWidth'(W);
            end
            lem_pkg::OP_SQSTEP: begin
               rem_in  = cand_ge ? RemWidth'(cand - trial) : cand[RemWidth-1:0];
               root_in = {root_ff[RootWidth-2:0], cand_ge};
               rad_in  = rad_ff << 2;
               cnt_in  = cnt_ff - 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= W'(PosXReset);
         y_ff <= '0;
         z_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      t_ff      <= t_in;
      u_ff      <= u_in;
      sample_ff <= sample_in_d;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      sum_ff    <= sum_in;
      flag_ff   <= flag_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      cnt_ff    <= cnt_in;
   end

   assign root_ovf = |root_ff[RootWidth-1:RootWidth-2];
   assign magnitude = root_ovf ? {(W - 1){1'b1}} : root_ff[W-2:0];
   assign status.count_zero = (cnt_ff == '0);
   assign status.saturated  = flag_ff | root_ovf;

endmodule

// ===== sv/lorenz_euler_magnitude.sv =====
// Lorenz system advanced by one Euler step per request, returning the magnitude of state
// and sample. Each request carries one signed fixed-point sample (VALUE_WIDTH bits,
// FRAC_BITS fraction bits); the block steps x, y and z with sigma, rho, beta and step h,
// then returns floor(sqrt(x^2 + y^2 + z^2 + sample^2)) of the new state, clipped to the
// largest positive value, with a flag set if any intermediate was clipped. A microcoded
// sequencer runs a 44-step program over one shared multiplier (two passes per product,
// eleven products) and a square root that yields one bit per cycle. The next request is
// taken once the result has moved to the output register, a move that waits while a
// stalled result still holds that register. A finished result waits in the output
// register while the next request is accepted. Registers sit on the APB port at byte
// addresses 0 (sigma), 4 (rho), 8 (beta) and 12 (step h), or at 8-byte spacing with a
// 64-bit data bus when VALUE_WIDTH exceeds 32; write them only while the block is
// idle.
module lorenz_euler_magnitude #(
   parameter int VALUE_WIDTH = lem_pkg::VALUE_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = lem_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   req_valid,
   output logic                                                   req_stall,
   input  logic signed [VALUE_WIDTH-1:0]                          req_sample_in,
   output logic                                                   rsp_valid,
   input  logic                                                   rsp_stall,
   output logic        [VALUE_WIDTH-2:0]                          rsp_magnitude_out,
   output logic                                                   rsp_saturated,
   input  logic                                                   psel,
   input  logic                                                   penable,
   input  logic                                                   pwrite,
   input  logic [lem_pkg::csr_addr_width(VALUE_WIDTH)-1:0]        paddr,
   input  logic [lem_pkg::csr_data_width(VALUE_WIDTH)-1:0]        pwdata,
   output logic [lem_pkg::csr_data_width(VALUE_WIDTH)-1:0]        prdata,
   output logic                                                   pready
);

   localparam int W          = VALUE_WIDTH;
   localparam int F          = FRAC_BITS;
   localparam int DataWidth  = lem_pkg::csr_data_width(VALUE_WIDTH);
   localparam int AddrWidth  = lem_pkg::csr_addr_width(VALUE_WIDTH);
   localparam int AddrShift  = lem_pkg::csr_addr_shift(VALUE_WIDTH);

   localparam longint OneQ     = longint'(1) << F;
   localparam longint VMaxL    = (longint'(1) << (W - 1)) - 1;
   localparam longint SigmaRaw = 10 * OneQ;
   localparam longint RhoRaw   = 28 * OneQ;
   localparam longint BetaRaw  = (16 * OneQ + 3) / 6;
   localparam longint SigmaRst = (SigmaRaw > VMaxL) ? VMaxL : SigmaRaw;
   localparam longint RhoRst   = (RhoRaw > VMaxL) ? VMaxL : RhoRaw;
   localparam longint BetaRst  = (BetaRaw > VMaxL) ? VMaxL : BetaRaw;
   localparam longint StepRst  = ((OneQ + 50) / 100) & ((longint'(1) << (F + 1)) - 1);

   logic signed [W-1:0]         sigma_ff, sigma_in, rho_ff, rho_in, beta_ff, beta_in;
   logic [F:0]                  hstep_ff, hstep_in;
   logic                        busy_ff, busy_in;
   lem_pkg::step_type           step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [W-2:0]                rsp_mag_ff, rsp_mag_in;
   logic                        rsp_sat_ff, rsp_sat_in;

   lem_pkg::reg_index_type      reg_idx;
   logic                        csr_write;
   logic                        accept;
   logic                        deliver;
   lem_pkg::ucode_type          ucode;
   lem_pkg::dp_status_type      dp_status;
   logic [W-2:0]                dp_magnitude;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[AddrWidth-1:AddrShift];
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      sigma_in = sigma_ff;
      rho_in   = rho_ff;
      beta_in  = beta_ff;
      hstep_in = hstep_ff;
      if (csr_write) begin
         case (reg_idx)
            lem_pkg::REG_SIGMA: sigma_in = signed'(pwdata[W-1:0]);
            lem_pkg::REG_RHO:   rho_in   = signed'(pwdata[W-1:0]);
            lem_pkg::REG_BETA:  beta_in  = signed'(pwdata[W-1:0]);
            lem_pkg::REG_STEP:  hstep_in = pwdata[F:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lem_pkg::REG_SIGMA: prdata = DataWidth'(sigma_ff);
         lem_pkg::REG_RHO:   prdata = DataWidth'(rho_ff);
         lem_pkg::REG_BETA:  prdata = DataWidth'(beta_ff);
         lem_pkg::REG_STEP:  prdata = DataWidth'(hstep_ff);
         default:            prdata = '0;
      endcase
   end

   // Sequencer: fetch the control word, advance, repeat the root step until its count runs out
   assign accept = req_valid & ~busy_ff;
   assign ucode  = busy_ff ? lem_pkg::prog_word(step_ff) : lem_pkg::UCODE_IDLE;

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      deliver      = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_mag_in   = rsp_mag_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (ucode.op == lem_pkg::OP_DONE) begin
            // hold until the output register is free
            if (~rsp_valid_ff | ~rsp_stall) begin
               deliver = 1'b1;
               busy_in = 1'b0;
            end
         end else if (ucode.loop & ~dp_status.count_zero) begin
            step_in = ucode.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
      if (deliver) begin
         rsp_valid_in = 1'b1;
         rsp_mag_in   = dp_magnitude;
         rsp_sat_in   = dp_status.saturated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff     <= W'(SigmaRst);
         rho_ff       <= W'(RhoRst);
         beta_ff      <= W'(BetaRst);
         hstep_ff     <= (F + 1)'(StepRst);
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sigma_ff     <= sigma_in;
         rho_ff       <= rho_in;
         beta_ff      <= beta_in;
         hstep_ff     <= hstep_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mag_ff <= rsp_mag_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   lem_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .sample_in  (req_sample_in),
      .ucode      (ucode),
      .sigma_gain (sigma_ff),
      .rho_gain   (rho_ff),
      .beta_gain  (beta_ff),
      .step_size  (hstep_ff),
      .status     (dp_status),
      .magnitude  (dp_magnitude)
   );

   assign req_stall         = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_magnitude_out = rsp_mag_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

// ===== sv/lem_checker.sv =====
// Port-level checks for the Lorenz magnitude block and their binding to the top level
module lem_checker #(
   parameter int VALUE_WIDTH = lem_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic                                            clock,
   input logic                                            reset,
   input logic                                            req_valid,
   input logic                                            req_stall,
   input logic signed [VALUE_WIDTH-1:0]                   req_sample_in,
   input logic                                            rsp_valid,
   input logic                                            rsp_stall,
   input logic        [VALUE_WIDTH-2:0]                   rsp_magnitude_out,
   input logic                                            rsp_saturated
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_magnitude_out)
                                 && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // A stalled request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_sample_in))
      else $error("request changed while stalled");

   // One request at a time: an accepted request blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel open straight after an accept");

   // Reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // An idle block cannot produce a result in the next cycle
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared without work in progress");

endmodule

bind lorenz_euler_magnitude lem_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_lem_checker (.*);
